>>> src/lbb_pkg.sv
package lbb_pkg;

  // Number of LEDs that are really present, and the number of slots that
  // the result channel always shows.
  localparam int LED_COUNT  = 5;
  localparam int SLOT_COUNT = 5;
  localparam int IDX_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic [6:0]  FULL_LEVEL   = 7'd100;
  localparam logic [7:0]  LEVEL_LIMIT  = 8'd100;
  localparam logic [6:0]  DUTY_SCALE   = 7'd100;
  localparam logic [2:0]  LED_IDX_LIM  = 3'(LED_COUNT);
  localparam logic [4:0]  PWM_MASK_RST = 5'd10;

  localparam logic [6:0] MAX_BRIGHT_RST [SLOT_COUNT] =
    '{7'd100, 7'd80, 7'd100, 7'd90, 7'd100};

  // Configuration register indexes.
  localparam logic [2:0] REG_PWM_MASK  = 3'd0;
  localparam logic [2:0] REG_MAX_FIRST = 3'd1;

  typedef enum logic [1:0] {
    MODE_UPDATE    = 2'd0,
    MODE_SET_STATE = 2'd1,
    MODE_SET_LEVEL = 2'd2,
    MODE_QUERY     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SWEEP  = 2'd1,
    ST_FINISH = 2'd2
  } seq_state_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] now_tick;
    logic [2:0]  led_index;
    logic        switch_on;
    logic [15:0] period;
    logic [7:0]  level;
  } item_t;

  typedef struct packed {
    logic        on;
    logic        blink;
    logic        phase;
    logic [6:0]  level;
    logic [15:0] period;
    logic [31:0] stamp;
  } led_state_t;

  typedef struct packed {
    logic             busy;
    logic             step;
    logic             last;
    logic             load;
    logic [IDX_W-1:0] index;
  } seq_ctl_t;

  function automatic logic index_ok(input logic [2:0] idx);
    return idx < LED_IDX_LIM;
  endfunction

  function automatic logic item_accepted(input item_t it);
    logic ok;
    ok = index_ok(it.led_index);
    unique case (it.mode)
      MODE_UPDATE:    return 1'b1;
      MODE_SET_STATE: return ok;
      MODE_SET_LEVEL: return ok && (it.level <= LEVEL_LIMIT);
      MODE_QUERY:     return ok;
      default:        return 1'b0;
    endcase
  endfunction

endpackage

>>> src/lbb_unit.sv
module lbb_unit (
  input  lbb_pkg::item_t      item,
  input  lbb_pkg::led_state_t cur,
  input  logic [6:0]          ceiling,
  input  logic                pwm_bit,
  input  logic                hit,
  output lbb_pkg::led_state_t nxt,
  output logic [13:0]         duty
);
  import lbb_pkg::*;

  logic [31:0] elapsed;
  logic        due;
  logic [6:0]  clamped;
  logic [13:0] scaled;

  // Elapsed time wraps modulo 2^32 like the tick itself.
  assign elapsed = item.now_tick - cur.stamp;
  assign due     = cur.blink && (cur.period != 16'd0) &&
                   (elapsed >= {17'd0, cur.period[15:1]});
  assign clamped = ({1'b0, ceiling} < item.level) ? ceiling : item.level[6:0];

  always_comb begin
    nxt = cur;
    unique case (item.mode)
      MODE_UPDATE: begin
        if (due) begin
          nxt.phase = ~cur.phase;
          nxt.on    = ~cur.phase;
          nxt.stamp = item.now_tick;
        end
      end
      MODE_SET_STATE: begin
        if (hit) begin
          if (item.period != 16'd0) begin
            nxt.blink  = 1'b1;
            nxt.period = item.period;
            nxt.stamp  = item.now_tick;
            nxt.phase  = 1'b0;
          end else begin
            nxt.blink  = 1'b0;
            nxt.period = 16'd0;
            nxt.on     = item.switch_on;
          end
        end
      end
      MODE_SET_LEVEL: begin
        if (hit && (item.level <= LEVEL_LIMIT)) begin
          nxt.level = clamped;
        end
      end
      MODE_QUERY: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign scaled = 14'(nxt.level) * 14'(DUTY_SCALE);
  assign duty   = (nxt.on && pwm_bit) ? scaled : 14'd0;

endmodule

>>> src/lbb_seq.sv
module lbb_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_blocked,
  output lbb_pkg::seq_ctl_t ctl
);
  import lbb_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             last;

  assign last = (cnt_r == IDX_W'(LED_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (last) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_blocked) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.busy  = (state_r != ST_IDLE);
    ctl.step  = (state_r == ST_SWEEP);
    ctl.last  = (state_r == ST_SWEEP) && last;
    ctl.load  = (state_r == ST_FINISH) && !out_blocked;
    ctl.index = cnt_r;
  end

endmodule

>>> src/led_blink_brightness_controller.sv
// An accepted item shows its result once the sweep and the load into the
// output register are done, or later while the previous result is stalled.
// The block takes no new item until that result is loaded; one shared update
// unit visits the LEDs one per cycle.
// Reset (rst_n, synchronous, active low) clears the sequencer and the LED
// state, sets every brightness to 100 and the registers to their defaults.
module led_blink_brightness_controller (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_now_tick,
  input  logic [2:0]  in_led_index,
  input  logic        in_switch_on,
  input  logic [15:0] in_blink_half_source,
  input  logic [7:0]  in_level_request,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [4:0]  out_on_bits,
  output logic [13:0] out_duty_led0,
  output logic [13:0] out_duty_led1,
  output logic [13:0] out_duty_led2,
  output logic [13:0] out_duty_led3,
  output logic [13:0] out_duty_led4,
  output logic [6:0]  out_sel_brightness,
  output logic        out_sel_blinking,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);
  import lbb_pkg::*;

  // Configuration registers. Writes are always taken; indexes beyond the
  // register list are dropped.
  logic [4:0] pwm_mask_r;
  logic [6:0] max_bright_r [SLOT_COUNT];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_mask_r <= PWM_MASK_RST;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        max_bright_r[i] <= MAX_BRIGHT_RST[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PWM_MASK) pwm_mask_r <= cfg_wdata[4:0];
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cfg_index == REG_MAX_FIRST + 3'(i)) max_bright_r[i] <= cfg_wdata;
      end
    end
  end

  // Sequencer: idle, then one cycle per LED, then a finish state that moves
  // the finished result into the output register once that register is free.
  seq_ctl_t ctl;
  logic     out_valid_r;
  logic     item_take;

  lbb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .out_blocked (out_valid_r && out_stall),
    .ctl         (ctl)
  );

  assign in_stall  = ctl.busy;
  assign item_take = in_valid && !in_stall;

  // The item is held for the whole sweep.
  item_t item_r, item_now;
  logic  accepted_r;

  always_comb begin
    item_now.mode      = mode_t'(in_mode);
    item_now.now_tick  = in_now_tick;
    item_now.led_index = in_led_index;
    item_now.switch_on = in_switch_on;
    item_now.period    = in_blink_half_source;
    item_now.level     = in_level_request;
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item_r     <= item_now;
      accepted_r <= item_accepted(item_now);
    end
  end

  // Per-LED state, written only at the LED the sweep is visiting; the on bits of all LEDs are read for the result.
  led_state_t led_r [LED_COUNT];
  led_state_t led_cur, led_nxt;
  logic [13:0] duty_step;
  logic [13:0] duty_w_r [LED_COUNT];
  logic        hit;
  logic        idx_ok;

  assign led_cur = led_r[ctl.index];
  assign idx_ok  = index_ok(item_r.led_index);
  assign hit     = idx_ok && (item_r.led_index == 3'(ctl.index));

  lbb_unit u_unit (
    .item    (item_r),
    .cur     (led_cur),
    .ceiling (max_bright_r[ctl.index]),
    .pwm_bit (pwm_mask_r[ctl.index]),
    .hit     (hit),
    .nxt     (led_nxt),
    .duty    (duty_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_r[i].on     <= 1'b0;
        led_r[i].blink  <= 1'b0;
        led_r[i].phase  <= 1'b0;
        led_r[i].level  <= FULL_LEVEL;
        led_r[i].period <= 16'd0;
        led_r[i].stamp  <= 32'd0;
      end
    end else if (ctl.step) begin
      led_r[ctl.index] <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) duty_w_r[ctl.index] <= duty_step;
  end

  // The addressed LED's status is caught as the sweep passes it; an invalid
  // index leaves both fields at zero.
  logic [6:0] sel_level_r;
  logic       sel_blink_r;

  always_ff @(posedge clk) begin
    if (item_take) begin
      sel_level_r <= 7'd0;
      sel_blink_r <= 1'b0;
    end else if (ctl.step && hit) begin
      sel_level_r <= led_nxt.level;
      sel_blink_r <= led_nxt.blink;
    end
  end

  // Output register: loaded when the sweep is done and the previous result
  // has been transferred or is being transferred in this cycle.
  logic        out_accepted_r;
  logic [4:0]  out_on_bits_r;
  logic [13:0] out_duty_r [SLOT_COUNT];
  logic [6:0]  out_sel_level_r;
  logic        out_sel_blink_r;
  logic [4:0]  on_now;

  always_comb begin
    on_now = 5'd0;
    for (int i = 0; i < LED_COUNT; i++) begin
      on_now[i] = led_r[i].on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_accepted_r  <= accepted_r;
      out_on_bits_r   <= on_now;
      out_sel_level_r <= sel_level_r;
      out_sel_blink_r <= sel_blink_r;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        out_duty_r[i] <= (i < LED_COUNT) ? duty_w_r[i] : 14'd0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_on_bits        = out_on_bits_r;
  assign out_duty_led0      = out_duty_r[0];
  assign out_duty_led1      = out_duty_r[1];
  assign out_duty_led2      = out_duty_r[2];
  assign out_duty_led3      = out_duty_r[3];
  assign out_duty_led4      = out_duty_r[4];
  assign out_sel_brightness = out_sel_level_r;
  assign out_sel_blinking   = out_sel_blink_r;

endmodule

>>> src/lbb_chk.sv
module lbb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_on_bits,
  input logic [13:0] out_duty_led0,
  input logic [6:0]  out_sel_brightness
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The block works on one item at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again during a sweep");

  // LED 0 has no duty while it is off.
  a_off_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_on_bits[0] |-> out_duty_led0 == 14'd0)
    else $error("duty shown for an LED that is off");

  // The shown brightness of the addressed LED never goes beyond full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sel_brightness <= 7'd100)
    else $error("brightness above full scale");

endmodule

bind led_blink_brightness_controller lbb_chk u_lbb_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_on_bits        (out_on_bits),
  .out_duty_led0      (out_duty_led0),
  .out_sel_brightness (out_sel_brightness)
);
